### rtl/sstf_pkg.sv
// Package with widths, register indexes and reset values for the servo sweep target finder.
package sstf_pkg;

    localparam int unsigned POS_W    = 16;
    localparam int unsigned RANGE_W  = 13;
    localparam int unsigned STEP_W   = 12;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 24;

    // Signed width that holds a position plus or minus a step.
    localparam int unsigned SUM_W = POS_W + 2;

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [RANGE_W-1:0] range_t;
    typedef logic [STEP_W-1:0]  step_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCAN_MODE  = 3'd0,
        CFG_THRESHOLD  = 3'd1,
        CFG_MIN_POS    = 3'd2,
        CFG_MAX_POS    = 3'd3,
        CFG_STEP_SIZE  = 3'd4
    } cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_CENTER   = 2'd0,
        MODE_FIRST    = 2'd1,
        MODE_TRAILING = 2'd2,
        MODE_UNUSED   = 2'd3
    } scan_mode_t;

    localparam logic [MODE_W-1:0]  RST_SCAN_MODE = MODE_CENTER;
    localparam logic [RANGE_W-1:0] RST_THRESHOLD = 13'd200;
    localparam logic [POS_W-1:0]   RST_MIN_POS   = 16'd1000;
    localparam logic [POS_W-1:0]   RST_MAX_POS   = 16'd4999;
    localparam logic [STEP_W-1:0]  RST_STEP_SIZE = 12'd10;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Saturate a signed sum to the position range.
    function automatic pos_t clamp_pos(input sum_t v);
        pos_t r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > sum_t'({2'b00, POS_MAX}))
        begin
            r = POS_MAX;
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/servo_sweep_target_finder.sv
// Top level of the servo sweep target finder: state update and registered result.
// A result is registered and appears on the master side in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle unless the output stalls; the sweep state updates in the accepting cycle.
// The output register frees in the same cycle its beat is taken, so no bubble is needed.
// Reset (rst_n low, asynchronous) clears the sweep state and output valid, and loads
// the configuration registers with their default values.
module servo_sweep_target_finder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: range_mm[12:0], range_valid[13], start_position[29:14], zero pad
    input  logic [sstf_pkg::IN_DATA_W-1:0]  s_tdata,
    // tuser: req_type (0 range reading, 1 start scan)
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: servo_position[15:0], scan_active[16], object_captured[17], zero pad
    output logic [sstf_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic [sstf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sstf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sstf_pkg::*;

    logic [MODE_W-1:0]  scan_mode_reg;
    range_t             threshold_reg;
    pos_t               min_pos_reg;
    pos_t               max_pos_reg;
    step_t              step_reg;

    pos_t   position_reg,  position_next;
    pos_t   captured_reg,  captured_next;
    logic   cap_flag_reg,  cap_flag_next;
    logic   dir_neg_reg,   dir_neg_next;
    logic   scanning_reg,  scanning_next;

    logic   out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic   s_fire;
    range_t range_mm;
    logic   range_valid;
    pos_t   start_position;
    logic   hit;

    sum_t   pos_plus;
    sum_t   pos_minus;
    sum_t   fwd_sum;
    sum_t   rev_sum;
    logic   in_bounds;
    pos_t   step_pos;
    pos_t   back_pos;
    sum_t   diff;
    sum_t   half_diff;
    pos_t   mid_pos;

    assign range_mm       = s_tdata[RANGE_W-1:0];
    assign range_valid    = s_tdata[RANGE_W];
    assign start_position = s_tdata[RANGE_W+POS_W:RANGE_W+1];

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign hit = (range_mm <= threshold_reg);

    // Both candidate moves are computed; the bound test picks one.
    assign pos_plus  = sum_t'({2'b00, position_reg}) + sum_t'({6'b0, step_reg});
    assign pos_minus = sum_t'({2'b00, position_reg}) - sum_t'({6'b0, step_reg});
    assign fwd_sum   = dir_neg_reg ? pos_minus : pos_plus;
    assign rev_sum   = dir_neg_reg ? pos_plus  : pos_minus;
    assign in_bounds = (fwd_sum > sum_t'({2'b00, min_pos_reg}))
                    && (fwd_sum < sum_t'({2'b00, max_pos_reg}));
    assign step_pos  = clamp_pos(in_bounds ? fwd_sum : rev_sum);
    assign back_pos  = clamp_pos(rev_sum);

    // Halving rounds toward zero, so a negative difference gets one added first.
    assign diff      = sum_t'({2'b00, position_reg}) - sum_t'({2'b00, captured_reg});
    assign half_diff = (diff + sum_t'({{(SUM_W-1){1'b0}}, diff[SUM_W-1]})) >>> 1;
    assign mid_pos   = clamp_pos(sum_t'({2'b00, captured_reg}) + half_diff);

    always_comb
    begin
        position_next = position_reg;
        captured_next = captured_reg;
        cap_flag_next = cap_flag_reg;
        dir_neg_next  = dir_neg_reg;
        scanning_next = scanning_reg;
        if (s_tuser)
        begin
            position_next = start_position;
            captured_next = '0;
            cap_flag_next = 1'b0;
            dir_neg_next  = 1'b0;
            scanning_next = 1'b1;
        end
        else if (scanning_reg && range_valid)
        begin
            if (hit)
            begin
                if (scan_mode_reg == MODE_FIRST)
                begin
                    scanning_next = 1'b0;
                end
                else
                begin
                    if (!cap_flag_reg)
                    begin
                        captured_next = position_reg;
                        cap_flag_next = 1'b1;
                    end
                    position_next = step_pos;
                    dir_neg_next  = dir_neg_reg ^ !in_bounds;
                end
            end
            else if (cap_flag_reg)
            begin
                scanning_next = 1'b0;
                position_next = (scan_mode_reg == MODE_TRAILING) ? back_pos : mid_pos;
            end
            else
            begin
                position_next = step_pos;
                dir_neg_next  = dir_neg_reg ^ !in_bounds;
            end
        end
    end

    always_comb
    begin
        out_data_next = '0;
        out_data_next[POS_W-1:0] = position_next;
        out_data_next[POS_W]     = scanning_next;
        out_data_next[POS_W+1]   = cap_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg <= RST_SCAN_MODE;
            threshold_reg <= RST_THRESHOLD;
            min_pos_reg   <= RST_MIN_POS;
            max_pos_reg   <= RST_MAX_POS;
            step_reg      <= RST_STEP_SIZE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCAN_MODE: scan_mode_reg <= cfg_data[MODE_W-1:0];
                CFG_THRESHOLD: threshold_reg <= cfg_data[RANGE_W-1:0];
                CFG_MIN_POS:   min_pos_reg   <= cfg_data[POS_W-1:0];
                CFG_MAX_POS:   max_pos_reg   <= cfg_data[POS_W-1:0];
                CFG_STEP_SIZE: step_reg      <= cfg_data[STEP_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            captured_reg  <= '0;
            cap_flag_reg  <= 1'b0;
            dir_neg_reg   <= 1'b0;
            scanning_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                position_reg <= position_next;
                captured_reg <= captured_next;
                cap_flag_reg <= cap_flag_next;
                dir_neg_reg  <= dir_neg_next;
                scanning_reg <= scanning_next;
            end
            if (s_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // A start beat always leaves the sweep running with the capture cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && s_tuser |=> scanning_reg && !cap_flag_reg && !dir_neg_reg)
        else $error("start beat did not restart the sweep");

    // Readings taken while idle must not move the servo.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && !s_tuser && !scanning_reg |=> $stable(position_reg))
        else $error("position moved while not scanning");

    // Each result beat reports the state left by its input beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> m_tvalid && (m_tdata[POS_W-1:0] == position_reg)
            && (m_tdata[POS_W] == scanning_reg) && (m_tdata[POS_W+1] == cap_flag_reg))
        else $error("result beat does not match sweep state");

    // A capture only appears on a good reading within the threshold.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cap_flag_reg) |-> $past(s_fire && !s_tuser && range_valid && hit))
        else $error("capture set without a hit");

endmodule

### bench/servo_sweep_target_finder_tb.sv
// Self-checking testbench for the servo sweep target finder: directed and random sweeps.
module servo_sweep_target_finder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sstf_pkg::*;

    typedef struct {
        logic   start_req;
        range_t range;
        logic   range_ok;
        pos_t   start_pos;
    } scan_beat_t;

    typedef struct {
        pos_t position;
        logic active;
        logic captured;
    } sweep_result_t;

    localparam int PHASE_ITEMS = 250;
    localparam int NUM_PHASES  = 8;
    localparam int LONG_STALL  = 300;
    localparam int MAX_REPORTS = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    servo_sweep_target_finder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Configuration as the testbench believes the block holds it.
    scan_mode_t cur_mode = scan_mode_t'(RST_SCAN_MODE);
    range_t     cur_thr  = RST_THRESHOLD;
    pos_t       cur_min  = RST_MIN_POS;
    pos_t       cur_max  = RST_MAX_POS;
    step_t      cur_step = RST_STEP_SIZE;

    // Predicted sweep state.
    pos_t sw_pos      = '0;
    pos_t sw_cap_pos  = '0;
    logic sw_cap_flag = 1'b0;
    logic sw_dir_neg  = 1'b0;
    logic sw_scanning = 1'b0;

    scan_beat_t    beat_q[$];
    sweep_result_t expected_sweep_q[$];
    scan_beat_t    drv_beat;
    scan_beat_t    seen_beat;
    sweep_result_t got;
    sweep_result_t want;

    int  n_queued = 0;
    int  n_accepted = 0;
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  stall_left = 0;
    bit  in_fire = 1'b0;
    bit  long_stall_go = 1'b0;
    bit  long_stall_done = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic pos_t sat_pos(input int v);
        pos_t r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > int'(POS_MAX))
        begin
            r = POS_MAX;
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    function automatic int step_inc();
        return sw_dir_neg ? -int'(cur_step) : int'(cur_step);
    endfunction

    function automatic void sweep_step();
        int s;
        int nxt;
        s = step_inc();
        nxt = int'(sw_pos) + s;
        // Leaving the open interval between the bounds turns the sweep around.
        if (!(nxt > int'(cur_min) && nxt < int'(cur_max)))
        begin
            sw_dir_neg = !sw_dir_neg;
            s = -s;
        end
        sw_pos = sat_pos(int'(sw_pos) + s);
    endfunction

    function automatic sweep_result_t predict_sweep(input scan_beat_t b);
        sweep_result_t r;
        if (b.start_req)
        begin
            sw_pos = b.start_pos;
            sw_dir_neg = 1'b0;
            sw_cap_flag = 1'b0;
            sw_cap_pos = '0;
            sw_scanning = 1'b1;
        end
        else if (sw_scanning && b.range_ok)
        begin
            if (b.range <= cur_thr)
            begin
                if (cur_mode == MODE_FIRST)
                begin
                    sw_scanning = 1'b0;
                end
                else
                begin
                    if (!sw_cap_flag)
                    begin
                        sw_cap_pos = sw_pos;
                        sw_cap_flag = 1'b1;
                    end
                    sweep_step();
                end
            end
            else if (sw_cap_flag)
            begin
                sw_scanning = 1'b0;
                if (cur_mode == MODE_TRAILING)
                begin
                    sw_pos = sat_pos(int'(sw_pos) - step_inc());
                end
                else
                begin
                    // Integer division truncates toward zero, also for a negative span.
                    sw_pos = sat_pos(int'(sw_cap_pos) + (int'(sw_pos) - int'(sw_cap_pos)) / 2);
                end
            end
            else
            begin
                sweep_step();
            end
        end
        r.position = sw_pos;
        r.active = sw_scanning;
        r.captured = sw_cap_flag;
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
            begin
                $display("mismatch on %s: expected %0d, got %0d", name, exp_v, act_v);
            end
        end
    endtask

    // Input acceptance, prediction and result checking.
    always @(posedge clk)
    begin
        in_fire = s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.position = m_tdata[15:0];
            got.active = m_tdata[16];
            got.captured = m_tdata[17];
            if (expected_sweep_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("unexpected result beat: position %0d", got.position);
                end
            end
            else
            begin
                want = expected_sweep_q.pop_front();
                check_field("servo_position", want.position, got.position);
                check_field("scan_active", want.active, got.active);
                check_field("object_captured", want.captured, got.captured);
            end
        end
        if (in_fire)
        begin
            seen_beat.start_req = s_tuser;
            seen_beat.range = s_tdata[12:0];
            seen_beat.range_ok = s_tdata[13];
            seen_beat.start_pos = s_tdata[29:14];
            expected_sweep_q.push_back(predict_sweep(seen_beat));
            n_accepted++;
        end
    end

    // Sender: offers queued beats, idling at random between them.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_fire)
        begin
            if (beat_q.size() != 0 && !($urandom_range(0, 99) < send_idle_pct))
            begin
                drv_beat = beat_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {2'b00, drv_beat.start_pos, drv_beat.range_ok, drv_beat.range};
                s_tuser <= drv_beat.start_req;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that backs up the input side.
    always @(negedge clk)
    begin
        if (long_stall_go && !long_stall_done)
        begin
            stall_left = LONG_STALL;
            long_stall_done = 1'b1;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic queue_beat(input logic req, input int rng, input logic ok, input int spos);
        scan_beat_t b;
        b.start_req = req;
        b.range = rng[RANGE_W-1:0];
        b.range_ok = ok;
        b.start_pos = spos[POS_W-1:0];
        beat_q.push_back(b);
        n_queued++;
    endtask

    task automatic wait_idle();
        while (n_accepted != n_queued || expected_sweep_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_SCAN_MODE: cur_mode = scan_mode_t'(val[MODE_W-1:0]);
            CFG_THRESHOLD: cur_thr = val[RANGE_W-1:0];
            CFG_MIN_POS:   cur_min = val;
            CFG_MAX_POS:   cur_max = val;
            CFG_STEP_SIZE: cur_step = val[STEP_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic pick_config(input int ph);
        int lo;
        int hi;
        if (ph == 0)
        begin
            write_reg(CFG_SCAN_MODE, 16'(MODE_TRAILING));
            write_reg(CFG_THRESHOLD, 16'd8191);
            write_reg(CFG_MIN_POS, 16'd0);
            write_reg(CFG_MAX_POS, 16'd65535);
            write_reg(CFG_STEP_SIZE, 16'd4095);
        end
        else if (ph == 1)
        begin
            write_reg(CFG_SCAN_MODE, 16'(MODE_UNUSED));
            write_reg(CFG_THRESHOLD, 16'd0);
            write_reg(CFG_MIN_POS, 16'd65535);
            write_reg(CFG_MAX_POS, 16'd0);
            write_reg(CFG_STEP_SIZE, 16'd0);
        end
        else
        begin
            write_reg(CFG_SCAN_MODE, 16'($urandom_range(0, 3)));
            write_reg(CFG_THRESHOLD, 16'($urandom_range(0, 8191)));
            if ($urandom_range(0, 99) < 85)
            begin
                lo = $urandom_range(0, 60000);
                hi = lo + $urandom_range(2, 5000);
            end
            else
            begin
                lo = $urandom_range(0, 65535);
                hi = $urandom_range(0, 65535);
            end
            write_reg(CFG_MIN_POS, lo[15:0]);
            write_reg(CFG_MAX_POS, hi[15:0]);
            if ($urandom_range(0, 99) < 80)
            begin
                write_reg(CFG_STEP_SIZE, 16'($urandom_range(1, 300)));
            end
            else
            begin
                write_reg(CFG_STEP_SIZE, 16'($urandom_range(0, 4095)));
            end
        end
    endtask

    // One start followed by a run of readings with a window of hits, possibly empty, somewhere in it.
    task automatic gen_sweep();
        int len;
        int hit_at;
        int hit_len;
        int spos;
        int rng;
        if (int'(cur_max) - int'(cur_min) > 1)
        begin
            spos = $urandom_range(int'(cur_min) + 1, int'(cur_max) - 1);
        end
        else
        begin
            spos = $urandom_range(0, 65535);
        end
        queue_beat(1'b1, $urandom_range(0, 8191), 1'($urandom_range(0, 1)), spos);
        len = $urandom_range(4, 40);
        hit_at = $urandom_range(0, len);
        hit_len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                queue_beat(1'b0, $urandom_range(0, 8191), 1'b0, $urandom_range(0, 65535));
            end
            else
            begin
                if (i >= hit_at && i < hit_at + hit_len)
                begin
                    rng = $urandom_range(0, int'(cur_thr));
                end
                else if (cur_thr == '1)
                begin
                    rng = 8191;
                end
                else
                begin
                    rng = $urandom_range(int'(cur_thr) + 1, 8191);
                end
                queue_beat(1'b0, rng, 1'b1, $urandom_range(0, 65535));
            end
        end
    endtask

    initial
    begin
        int phase_start;
        int kind;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: center mode, bounds 1000..4999, step 10.
        queue_beat(1'b0, 0, 1'b1, 0);
        queue_beat(1'b1, 8191, 1'b1, 2000);
        queue_beat(1'b0, 0, 1'b0, 0);
        queue_beat(1'b0, 8191, 1'b1, 65535);
        queue_beat(1'b0, 200, 1'b1, 0);
        queue_beat(1'b0, 0, 1'b1, 0);
        queue_beat(1'b0, 201, 1'b1, 0);
        queue_beat(1'b1, 0, 1'b0, 65535);
        queue_beat(1'b0, 8191, 1'b1, 0);
        queue_beat(1'b1, 0, 1'b0, 0);
        queue_beat(1'b0, 8191, 1'b1, 0);
        queue_beat(1'b1, 0, 1'b0, 4990);
        queue_beat(1'b0, 8191, 1'b1, 0);
        wait_idle();

        write_reg(CFG_SCAN_MODE, 16'(MODE_FIRST));
        queue_beat(1'b1, 0, 1'b0, 1500);
        queue_beat(1'b0, 0, 1'b1, 0);
        wait_idle();

        // Narrow upper bound so the sweep turns around and the center span goes negative.
        write_reg(CFG_SCAN_MODE, 16'(MODE_CENTER));
        write_reg(CFG_MAX_POS, 16'd2005);
        write_reg(CFG_STEP_SIZE, 16'd3);
        queue_beat(1'b1, 0, 1'b0, 2000);
        queue_beat(1'b0, 0, 1'b1, 0);
        queue_beat(1'b0, 0, 1'b1, 0);
        queue_beat(1'b0, 0, 1'b1, 0);
        queue_beat(1'b0, 8191, 1'b1, 0);
        wait_idle();

        // A larger step written mid-scan makes the step back saturate at the top.
        write_reg(CFG_SCAN_MODE, 16'(MODE_TRAILING));
        write_reg(CFG_MIN_POS, 16'd0);
        write_reg(CFG_MAX_POS, 16'd65535);
        write_reg(CFG_STEP_SIZE, 16'd10);
        queue_beat(1'b1, 0, 1'b0, 65530);
        queue_beat(1'b0, 0, 1'b1, 0);
        wait_idle();
        write_reg(CFG_STEP_SIZE, 16'd4095);
        queue_beat(1'b0, 8191, 1'b1, 0);
        wait_idle();

        // Unused mode, zero step and inverted bounds together.
        write_reg(CFG_SCAN_MODE, 16'(MODE_UNUSED));
        write_reg(CFG_STEP_SIZE, 16'd0);
        write_reg(CFG_MIN_POS, 16'd5000);
        write_reg(CFG_MAX_POS, 16'd100);
        queue_beat(1'b1, 0, 1'b0, 3000);
        queue_beat(1'b0, 8191, 1'b1, 0);
        queue_beat(1'b0, 0, 1'b1, 0);
        queue_beat(1'b0, 8191, 1'b1, 0);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            pick_config(ph);
            kind = ph % 4;
            send_idle_pct = (kind == 1) ? 63 : (kind == 3) ? 37 : 0;
            recv_stall_pct = (kind == 2) ? 63 : (kind == 3) ? 37 : 0;
            if (ph == 4)
            begin
                long_stall_go = 1'b1;
            end
            phase_start = n_queued;
            while (n_queued - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    queue_beat($urandom_range(0, 3) == 0, $urandom_range(0, 8191),
                               1'($urandom_range(0, 1)), $urandom_range(0, 65535));
                end
                else
                begin
                    gen_sweep();
                end
            end
            wait_idle();
        end

        repeat (5) @(posedge clk);
        if (expected_sweep_q.size() != 0)
        begin
            errors++;
        end
        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
